// ===== rtl/core/stcb_pkg.sv =====
// Shared constants, codes and control types of the scrolling text console buffer.
`default_nettype none

package stcb_pkg;

    localparam int ROWS_MAX = 32;
    localparam int COLS_MAX = 128;

    localparam int ROW_W  = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
    localparam int COL_W  = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1;
    localparam int RCNT_W = $clog2(ROWS_MAX + 1);
    localparam int CCNT_W = $clog2(COLS_MAX + 1);
    localparam int PSUM_W = RCNT_W + 1;
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    localparam int MODE_W     = 2;
    localparam int CHAR_W     = 8;
    localparam int RROW_W     = 5;
    localparam int RCOL_W     = 7;
    localparam int CROWS_W    = 6;
    localparam int CCOLS_W    = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

    localparam logic [CROWS_W-1:0] CFG_ROWS_RESET = 6'd32;
    localparam logic [CCOLS_W-1:0] CFG_COLS_RESET = 8'd128;

    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;

    typedef enum logic [5:0] {
        ST_IDLE       = 6'b000001,
        ST_DECODE     = 6'b000010,
        ST_SWEEP_LF   = 6'b000100,
        ST_SWEEP_FILL = 6'b001000,
        ST_READ       = 6'b010000,
        ST_RESP       = 6'b100000
    } state_t;

    typedef struct packed {
        logic load_item;
        logic do_clear;
        logic write_char;
        logic advance;
        logic line_feed;
        logic sweep_lf_init;
        logic sweep_fill_init;
        logic sweep_write;
        logic set_valid;
        logic read_issue;
        logic read_capture;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              is_cr;
        logic              is_lf;
        logic              row_valid;
        logic              rd_in_range;
        logic              sweep_last;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/stcb_channels.sv =====
// Handshake channel interfaces: request, response and configuration write.
`default_nettype none

interface stcb_req_if;
    logic                             valid;
    logic                             ready;
    logic [stcb_pkg::MODE_W-1:0]      mode;
    logic [stcb_pkg::CHAR_W-1:0]      char_code;
    logic [stcb_pkg::RROW_W-1:0]      read_row;
    logic [stcb_pkg::RCOL_W-1:0]      read_column;

    modport source (output valid, mode, char_code, read_row, read_column, input ready);
    modport sink   (input valid, mode, char_code, read_row, read_column, output ready);
endinterface

interface stcb_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [stcb_pkg::CHAR_W-1:0]      read_char;
    logic [stcb_pkg::RCOL_W-1:0]      cursor_column;
    logic [stcb_pkg::RROW_W-1:0]      cursor_row;
    logic [stcb_pkg::RROW_W-1:0]      top_row;

    modport source (output valid, read_char, cursor_column, cursor_row, top_row,
                    input ready);
    modport sink   (input valid, read_char, cursor_column, cursor_row, top_row,
                    output ready);
endinterface

interface stcb_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [stcb_pkg::CFG_IDX_W-1:0]     index;
    logic [stcb_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/stcb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module stcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/stcb_ctrl.sv =====
// Controller state machine: sequences one transaction through the datapath.
`default_nettype none

module stcb_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output      logic             req_ready,
    output      logic             rsp_valid,
    input  wire logic             rsp_ready,
    input  wire logic             cfg_valid,
    output      logic             cfg_ready,
    input  wire stcb_pkg::status_t status,
    output      stcb_pkg::cmd_t   cmd
);

    stcb_pkg::state_t state_reg;
    stcb_pkg::state_t state_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    logic             idle;

    assign idle      = (state_reg == stcb_pkg::ST_IDLE);
    assign cfg_ready = idle;
    // Take a request only when the response register is free or draining now.
    assign req_ready = idle && !cfg_valid && (!rsp_valid_reg || rsp_ready);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            stcb_pkg::ST_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = stcb_pkg::ST_DECODE;
                end
            end
            stcb_pkg::ST_DECODE:
            begin
                state_next = stcb_pkg::ST_RESP;
                case (status.mode)
                    stcb_pkg::MODE_PUT:
                    begin
                        if (status.is_cr)
                        begin
                            state_next = stcb_pkg::ST_RESP;
                        end
                        else if (status.is_lf)
                        begin
                            if (status.row_valid)
                            begin
                                cmd.sweep_lf_init = 1'b1;
                                state_next        = stcb_pkg::ST_SWEEP_LF;
                            end
                            else
                            begin
                                cmd.line_feed = 1'b1;
                            end
                        end
                        else if (status.row_valid)
                        begin
                            cmd.write_char = 1'b1;
                            cmd.advance    = 1'b1;
                        end
                        else
                        begin
                            // Fresh row: blank it while placing the character.
                            cmd.sweep_fill_init = 1'b1;
                            state_next          = stcb_pkg::ST_SWEEP_FILL;
                        end
                    end
                    stcb_pkg::MODE_CLEAR:
                    begin
                        cmd.do_clear = 1'b1;
                    end
                    stcb_pkg::MODE_READ:
                    begin
                        if (status.rd_in_range)
                        begin
                            cmd.read_issue = 1'b1;
                            state_next     = stcb_pkg::ST_READ;
                        end
                    end
                    default:
                    begin
                        state_next = stcb_pkg::ST_RESP;
                    end
                endcase
            end
            stcb_pkg::ST_SWEEP_LF:
            begin
                cmd.sweep_write = 1'b1;
                if (status.sweep_last)
                begin
                    cmd.line_feed = 1'b1;
                    state_next    = stcb_pkg::ST_RESP;
                end
            end
            stcb_pkg::ST_SWEEP_FILL:
            begin
                cmd.sweep_write = 1'b1;
                if (status.sweep_last)
                begin
                    cmd.set_valid = 1'b1;
                    cmd.advance   = 1'b1;
                    state_next    = stcb_pkg::ST_RESP;
                end
            end
            stcb_pkg::ST_READ:
            begin
                cmd.read_capture = 1'b1;
                state_next       = stcb_pkg::ST_RESP;
            end
            stcb_pkg::ST_RESP:
            begin
                cmd.out_load = 1'b1;
                state_next   = stcb_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = stcb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stcb_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/stcb_dpath.sv =====
// Datapath: geometry, cursor, ring pointers, row valid flags and the text store.
`default_nettype none

module stcb_dpath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr,
    input  wire logic [stcb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [stcb_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [stcb_pkg::MODE_W-1:0]       mode,
    input  wire logic [stcb_pkg::CHAR_W-1:0]       char_code,
    input  wire logic [stcb_pkg::RROW_W-1:0]       read_row,
    input  wire logic [stcb_pkg::RCOL_W-1:0]       read_column,
    input  wire stcb_pkg::cmd_t                    cmd,
    output      stcb_pkg::status_t                 status,
    output      logic [stcb_pkg::CHAR_W-1:0]       rsp_read_char,
    output      logic [stcb_pkg::RCOL_W-1:0]       rsp_cursor_column,
    output      logic [stcb_pkg::RROW_W-1:0]       rsp_cursor_row,
    output      logic [stcb_pkg::RROW_W-1:0]       rsp_top_row
);

    localparam int ROW_W  = stcb_pkg::ROW_W;
    localparam int COL_W  = stcb_pkg::COL_W;
    localparam int RCNT_W = stcb_pkg::RCNT_W;
    localparam int CCNT_W = stcb_pkg::CCNT_W;
    localparam int PSUM_W = stcb_pkg::PSUM_W;
    localparam int ADDR_W = stcb_pkg::ADDR_W;
    localparam int CHAR_W = stcb_pkg::CHAR_W;

    // Geometry registers
    logic [stcb_pkg::CROWS_W-1:0] rows_cfg_reg, rows_cfg_next;
    logic [stcb_pkg::CCOLS_W-1:0] cols_cfg_reg, cols_cfg_next;
    logic [RCNT_W-1:0]            eff_rows;
    logic [CCNT_W-1:0]            eff_cols;

    // Cursor and ring pointers
    logic [COL_W-1:0]              cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]              cur_row_reg, cur_row_next;
    logic [ROW_W-1:0]              top_reg, top_next;
    logic [ROW_W-1:0]              ins_reg, ins_next;
    logic [stcb_pkg::ROWS_MAX-1:0] row_valid_reg, row_valid_next;

    // Latched item
    logic [stcb_pkg::MODE_W-1:0] mode_reg;
    logic [CHAR_W-1:0]           char_reg;
    logic [stcb_pkg::RROW_W-1:0] rrow_reg;
    logic [stcb_pkg::RCOL_W-1:0] rcol_reg;

    // Sweep and read
    logic [COL_W-1:0]  sweep_cnt_reg, sweep_cnt_next;
    logic [COL_W-1:0]  sweep_end_reg, sweep_end_next;
    logic              sweep_fill_reg, sweep_fill_next;
    logic              rd_hit_reg, rd_hit_next;
    logic [CHAR_W-1:0] rd_char_reg, rd_char_next;
    logic [CHAR_W-1:0] mem_q;

    // Newline and advance arithmetic
    logic [RCNT_W-1:0] row_p1, top_p1, ins_p1;
    logic              scroll;
    logic [ROW_W-1:0]  nl_row, nl_top, nl_ins;
    logic [CCNT_W-1:0] col_p1;
    logic              col_wrap;
    logic              newline;

    // Read addressing
    logic [PSUM_W-1:0] phys_sum;
    logic [ROW_W-1:0]  phys_row;
    logic              rd_in_range;

    // Store port signals
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CHAR_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    always_comb
    begin
        if (rows_cfg_reg == '0)
        begin
            eff_rows = RCNT_W'(1);
        end
        else if (int'(rows_cfg_reg) > stcb_pkg::ROWS_MAX)
        begin
            eff_rows = RCNT_W'(stcb_pkg::ROWS_MAX);
        end
        else
        begin
            eff_rows = RCNT_W'(rows_cfg_reg);
        end

        if (cols_cfg_reg == '0)
        begin
            eff_cols = CCNT_W'(1);
        end
        else if (int'(cols_cfg_reg) > stcb_pkg::COLS_MAX)
        begin
            eff_cols = CCNT_W'(stcb_pkg::COLS_MAX);
        end
        else
        begin
            eff_cols = CCNT_W'(cols_cfg_reg);
        end
    end

    assign row_p1   = RCNT_W'(cur_row_reg) + RCNT_W'(1);
    assign top_p1   = RCNT_W'(top_reg) + RCNT_W'(1);
    assign ins_p1   = RCNT_W'(ins_reg) + RCNT_W'(1);
    assign scroll   = (row_p1 >= eff_rows);
    assign nl_row   = scroll ? cur_row_reg : row_p1[ROW_W-1:0];
    assign nl_top   = scroll ? ((top_p1 >= eff_rows) ? '0 : top_p1[ROW_W-1:0]) : top_reg;
    // The insert row always steps by one, whether the cursor moves or the ring scrolls.
    assign nl_ins   = (ins_p1 >= eff_rows) ? '0 : ins_p1[ROW_W-1:0];
    assign col_p1   = CCNT_W'(cur_col_reg) + CCNT_W'(1);
    assign col_wrap = (col_p1 >= eff_cols);
    assign newline  = cmd.line_feed || (cmd.advance && col_wrap);

    assign phys_sum    = PSUM_W'(top_reg) + PSUM_W'(rrow_reg);
    assign phys_row    = (phys_sum >= PSUM_W'(eff_rows)) ?
                         ROW_W'(phys_sum - PSUM_W'(eff_rows)) : ROW_W'(phys_sum);
    assign rd_in_range = (PSUM_W'(rrow_reg) < PSUM_W'(eff_rows)) &&
                         (CCNT_W'(rcol_reg) < eff_cols);

    always_comb
    begin
        rows_cfg_next   = rows_cfg_reg;
        cols_cfg_next   = cols_cfg_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        top_next        = top_reg;
        ins_next        = ins_reg;
        row_valid_next  = row_valid_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        sweep_end_next  = sweep_end_reg;
        sweep_fill_next = sweep_fill_reg;
        rd_hit_next     = rd_hit_reg;
        rd_char_next    = rd_char_reg;

        if (cfg_wr)
        begin
            if (cfg_index == stcb_pkg::CFG_ROWS)
            begin
                rows_cfg_next = cfg_data[stcb_pkg::CROWS_W-1:0];
            end
            else
            begin
                cols_cfg_next = cfg_data[stcb_pkg::CCOLS_W-1:0];
            end
        end

        if (cmd.load_item)
        begin
            rd_char_next = '0;
        end

        if (cmd.sweep_lf_init)
        begin
            sweep_cnt_next  = cur_col_reg;
            sweep_end_next  = COL_W'(eff_cols - CCNT_W'(1));
            sweep_fill_next = 1'b0;
        end
        if (cmd.sweep_fill_init)
        begin
            sweep_cnt_next  = '0;
            sweep_end_next  = COL_W'(stcb_pkg::COLS_MAX - 1);
            sweep_fill_next = 1'b1;
        end
        if (cmd.sweep_write)
        begin
            sweep_cnt_next = sweep_cnt_reg + COL_W'(1);
        end

        if (cmd.read_issue)
        begin
            rd_hit_next = row_valid_reg[phys_row];
        end
        if (cmd.read_capture)
        begin
            rd_char_next = rd_hit_reg ? mem_q : stcb_pkg::CHAR_SPACE;
        end

        if (cmd.set_valid)
        begin
            row_valid_next[ins_reg] = 1'b1;
        end

        if (cmd.advance && !col_wrap)
        begin
            cur_col_next = col_p1[COL_W-1:0];
        end
        if (newline)
        begin
            cur_col_next            = '0;
            cur_row_next            = nl_row;
            top_next                = nl_top;
            ins_next                = nl_ins;
            // Drop the new row's flag: it now reads as blank.
            row_valid_next[nl_ins]  = 1'b0;
        end

        if (cmd.do_clear || cfg_wr)
        begin
            cur_col_next   = '0;
            cur_row_next   = '0;
            top_next       = '0;
            ins_next       = '0;
            row_valid_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg  <= stcb_pkg::CFG_ROWS_RESET;
            cols_cfg_reg  <= stcb_pkg::CFG_COLS_RESET;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            top_reg       <= '0;
            ins_reg       <= '0;
            row_valid_reg <= '0;
        end
        else
        begin
            rows_cfg_reg  <= rows_cfg_next;
            cols_cfg_reg  <= cols_cfg_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            top_reg       <= top_next;
            ins_reg       <= ins_next;
            row_valid_reg <= row_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sweep_cnt_reg  <= sweep_cnt_next;
        sweep_end_reg  <= sweep_end_next;
        sweep_fill_reg <= sweep_fill_next;
        rd_hit_reg     <= rd_hit_next;
        rd_char_reg    <= rd_char_next;
        if (cmd.load_item)
        begin
            mode_reg <= mode;
            char_reg <= char_code;
            rrow_reg <= read_row;
            rcol_reg <= read_column;
        end
        if (cmd.out_load)
        begin
            rsp_read_char     <= rd_char_reg;
            rsp_cursor_column <= stcb_pkg::RCOL_W'(cur_col_reg);
            rsp_cursor_row    <= stcb_pkg::RROW_W'(cur_row_reg);
            rsp_top_row       <= stcb_pkg::RROW_W'(top_reg);
        end
    end

    assign mem_we    = cmd.write_char || cmd.sweep_write;
    assign mem_waddr = cmd.sweep_write ? {ins_reg, sweep_cnt_reg} : {ins_reg, cur_col_reg};
    assign mem_wdata = (cmd.sweep_write && !(sweep_fill_reg && sweep_cnt_reg == cur_col_reg)) ?
                       stcb_pkg::CHAR_SPACE : char_reg;
    assign mem_raddr = {phys_row, COL_W'(rcol_reg)};

    stcb_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (stcb_pkg::MEM_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (cmd.read_issue),
        .rd_addr (mem_raddr),
        .rd_data (mem_q)
    );

    assign status.mode        = mode_reg;
    assign status.is_cr       = (char_reg == stcb_pkg::CHAR_CR);
    assign status.is_lf       = (char_reg == stcb_pkg::CHAR_LF);
    assign status.row_valid   = row_valid_reg[ins_reg];
    assign status.rd_in_range = rd_in_range;
    assign status.sweep_last  = (sweep_cnt_reg == sweep_end_reg);

endmodule

`default_nettype wire

// ===== rtl/core/scrolling_text_console_buffer.sv =====
// Scrolling text console buffer: top level joining controller and datapath.
//
// Channels: req carries one transaction (mode, char_code, read_row,
// read_column); rsp returns exactly one result per request (read_char,
// cursor_column, cursor_row, top_row); cfg writes rows_in_use (index 0) or
// columns_in_use (index 1), and each write also clears the screen.
// Timing: one request at a time. A plain put, a carriage return, a clear or
// an out-of-range read passes through decode and the response state, and the
// next request is taken once the controller is back in idle. An in-range read
// adds a read state for the registered store read. A line feed on a row that
// already holds text adds a sweep that blanks the rest of the row. The first
// character put into a fresh row adds a sweep over all 128 store columns, as
// the store row is blanked while the character is written.
// Reset: cursor, top and insert rows go to zero, geometry to 32 x 128, and
// every row flag drops, so the whole store reads as spaces at once with no
// clearing pass. A clear drops all the row flags together in the same way.
// Stall: a finished result holds in the response register while rsp.ready is
// low; the next request is taken once that register drains, if cfg.valid is low.
`default_nettype none

module scrolling_text_console_buffer (
    input  wire logic clk,
    input  wire logic rst_n,
    stcb_cfg_if.sink  cfg,
    stcb_req_if.sink  req,
    stcb_rsp_if.source rsp
);

    stcb_pkg::cmd_t    cmd;
    stcb_pkg::status_t status;
    logic              cfg_wr;

    assign cfg_wr = cfg.valid && cfg.ready;

    stcb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cfg_valid (cfg.valid),
        .cfg_ready (cfg.ready),
        .status    (status),
        .cmd       (cmd)
    );

    stcb_dpath u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr            (cfg_wr),
        .cfg_index         (cfg.index),
        .cfg_data          (cfg.data),
        .mode              (req.mode),
        .char_code         (req.char_code),
        .read_row          (req.read_row),
        .read_column       (req.read_column),
        .cmd               (cmd),
        .status            (status),
        .rsp_read_char     (rsp.read_char),
        .rsp_cursor_column (rsp.cursor_column),
        .rsp_cursor_row    (rsp.cursor_row),
        .rsp_top_row       (rsp.top_row)
    );

`ifndef SYNTHESIS
    a_no_req_over_full_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |-> (!rsp.valid || rsp.ready))
        else $error("request taken while response register is held");

    a_no_cfg_with_req: assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg_wr && req.valid && req.ready))
        else $error("configuration write and request in the same cycle");

    a_single_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.write_char && cmd.sweep_write))
        else $error("direct write and row sweep collide on the store port");

    a_rsp_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> rsp.valid)
        else $error("response not presented after result load");
`endif

endmodule

`default_nettype wire
